FILE: rtl/core/sle_pkg.sv
// sle_pkg: shared types and field widths of the sequence list engine.
// No dependencies; imported by the channel interfaces and all core modules.
package sle_pkg;

  localparam int unsigned OpW     = 2;
  localparam int unsigned ItemW   = 32;
  localparam int unsigned PosW    = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned IndexW  = 5;
  localparam int unsigned LengthW = 6;

  typedef enum logic [OpW-1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_BACK  = 2'd1,
    OP_DELETE    = 2'd2,
    OP_DUMP      = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_INVALID = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  // decoded command as it sits in the front queue
  typedef struct packed {
    op_e             op;
    logic [ItemW-1:0] value;
    logic [PosW-1:0]  position;
  } cmd_t;

  // head of the front queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

FILE: rtl/core/sle_channels.sv
// sle_in_if / sle_out_if: valid/ready channels of the sequence list engine.
// Depends on sle_pkg for field widths.
interface sle_in_if import sle_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OpW-1:0]          op;
  logic signed [ItemW-1:0] item_value;
  logic [PosW-1:0]         position;

  modport source (output valid, op, item_value, position, input ready);
  modport sink   (input valid, op, item_value, position, output ready);
endinterface

interface sle_out_if import sle_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [StatusW-1:0]      status;
  logic signed [ItemW-1:0] elem_value;
  logic [IndexW-1:0]       elem_index;
  logic                    last_of_run;
  logic [LengthW-1:0]      length_now;

  modport source (output valid, status, elem_value, elem_index, last_of_run, length_now,
                  input ready);
  modport sink   (input valid, status, elem_value, elem_index, last_of_run, length_now,
                  output ready);
endinterface

FILE: rtl/core/sle_front.sv
// sle_front: accepts input words, decodes the op and holds them in a two-entry queue.
// Depends on sle_pkg and sle_in_if.
module sle_front import sle_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  sle_in_if.sink        in_i,
  output queue_head_t   head_o,
  input  logic          pop_i
);

  localparam int unsigned Depth = 2;

  cmd_t       entry_q [Depth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push;
  cmd_t       cmd_in;

  assign in_i.ready = (fill_q != 2'(Depth));
  assign push       = in_i.valid && in_i.ready;

  always_comb begin
    cmd_in.op       = op_e'(in_i.op);
    cmd_in.value    = in_i.item_value;
    cmd_in.position = in_i.position;
  end

  assign head_o.valid = (fill_q != 2'd0);
  assign head_o.cmd   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_q + 2'(push) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

FILE: rtl/core/sle_back.sv
// sle_back: executes queued commands on the circular element store, owns the output register.
// Depends on sle_pkg and sle_out_if.
module sle_back import sle_pkg::*; #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  queue_head_t head_i,
  output logic        pop_o,
  sle_out_if.source   out_o
);

  localparam int unsigned SW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > PosW) ? CW : PosW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEL_RD,
    S_DEL_WR,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_e;

  function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] h, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(i);
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return s[SW-1:0];
  endfunction

  // element store and its registered read port
  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] rd_data_q;
  logic                  we, re;
  logic [SW-1:0]         waddr, raddr;
  logic [VALUE_BITS-1:0] wdata;

  state_e                state_q, state_d;
  logic [SW-1:0]         head_q, head_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         idx_nx;

  logic                  res_valid_q;
  status_e               res_status_q;
  logic [VALUE_BITS-1:0] res_value_q;
  logic [CW-1:0]         res_index_q;
  logic                  res_last_q;
  logic [CW-1:0]         res_length_q;

  logic                  res_free, res_load;
  status_e               res_status;
  logic [VALUE_BITS-1:0] res_value;
  logic [CW-1:0]         res_index;
  logic                  res_last;
  logic                  is_full, is_empty, pos_bad;
  logic [ItemW-1:0]      value_raw;

  assign res_free  = !res_valid_q || out_o.ready;
  assign is_full   = (count_q == CW'(CAPACITY));
  assign is_empty  = (count_q == '0);
  assign pos_bad   = (CMPW'(head_i.cmd.position) >= CMPW'(count_q));
  assign idx_nx    = idx_q + 1'b1;
  assign value_raw = head_i.cmd.value;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    idx_d      = idx_q;
    we         = 1'b0;
    waddr      = '0;
    wdata      = VALUE_BITS'(value_raw);
    re         = 1'b0;
    raddr      = '0;
    pop_o      = 1'b0;
    res_load   = 1'b0;
    res_status = STAT_OK;
    res_value  = '0;
    res_index  = '0;
    res_last   = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (head_i.valid && res_free) begin
          case (head_i.cmd.op)
            OP_INS_FRONT: begin
              res_load = 1'b1;
              pop_o    = 1'b1;
              if (is_full) begin
                res_status = STAT_FULL;
              end else begin
                head_d  = (head_q == '0) ? SW'(CAPACITY - 1) : head_q - 1'b1;
                we      = 1'b1;
                waddr   = head_d;
                count_d = count_q + 1'b1;
              end
            end
            OP_INS_BACK: begin
              res_load = 1'b1;
              pop_o    = 1'b1;
              if (is_full) begin
                res_status = STAT_FULL;
              end else begin
                we      = 1'b1;
                waddr   = slot_of(head_q, count_q);
                count_d = count_q + 1'b1;
              end
            end
            OP_DELETE: begin
              if (is_empty) begin
                res_load   = 1'b1;
                pop_o      = 1'b1;
                res_status = STAT_EMPTY;
              end else if (pos_bad) begin
                res_load   = 1'b1;
                pop_o      = 1'b1;
                res_status = STAT_INVALID;
              end else begin
                idx_d   = CW'(head_i.cmd.position);
                state_d = S_DEL_RD;
              end
            end
            OP_DUMP: begin
              if (is_empty) begin
                res_load   = 1'b1;
                pop_o      = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = S_DUMP_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_DEL_RD: begin
        if (idx_nx < count_q) begin
          re      = 1'b1;
          raddr   = slot_of(head_q, idx_nx);
          state_d = S_DEL_WR;
        end else if (res_free) begin
          count_d  = count_q - 1'b1;
          res_load = 1'b1;
          pop_o    = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_DEL_WR: begin
        we      = 1'b1;
        waddr   = slot_of(head_q, idx_q);
        wdata   = rd_data_q;
        idx_d   = idx_nx;
        state_d = S_DEL_RD;
      end
      S_DUMP_RD: begin
        re      = 1'b1;
        raddr   = slot_of(head_q, idx_q);
        state_d = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (res_free) begin
          res_load  = 1'b1;
          res_value = rd_data_q;
          res_index = idx_q;
          res_last  = (idx_nx == count_q);
          if (res_last) begin
            pop_o   = 1'b1;
            state_d = S_IDLE;
          end else begin
            // fetch the next element while this one sits in the output register
            re    = 1'b1;
            raddr = slot_of(head_q, idx_nx);
            idx_d = idx_nx;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      res_valid_q  <= 1'b0;
      res_status_q <= STAT_OK;
      res_value_q  <= '0;
      res_index_q  <= '0;
      res_last_q   <= 1'b0;
      res_length_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (res_load) begin
        res_valid_q  <= 1'b1;
        res_status_q <= res_status;
        res_value_q  <= res_value;
        res_index_q  <= res_index;
        res_last_q   <= res_last;
        res_length_q <= count_d;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rd_data_q <= mem[raddr];
    end
  end

  assign out_o.valid       = res_valid_q;
  assign out_o.status      = res_status_q;
  assign out_o.elem_value  = $signed(ItemW'(res_value_q));
  assign out_o.elem_index  = IndexW'(res_index_q);
  assign out_o.last_of_run = res_last_q;
  assign out_o.length_now  = LengthW'(res_length_q);

  // every retired command leaves a result in the output register
  a_pop_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> res_load)
    else $error("command retired without a result");

  // a final result of a run always retires its command
  a_last_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && res_last) |-> pop_o)
    else $error("last result without retiring the command");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && res_load && res_status == STAT_OK &&
     (head_i.cmd.op == OP_INS_FRONT || head_i.cmd.op == OP_INS_BACK))
    |=> count_q == $past(count_q) + 1'b1)
    else $error("successful insert did not grow the list");

endmodule

FILE: rtl/core/sequence_list_engine.sv
// sequence_list_engine: top level of the double-ended list with positional delete.
// Depends on sle_pkg, sle_channels (sle_in_if, sle_out_if), sle_front and sle_back.
//
// Usage:
//   in_i  (sle_in_if.sink): one word per command: op, item_value, position.
//   out_o (sle_out_if.source): result words: status, elem_value, elem_index,
//         last_of_run, length_now. last_of_run marks the final word of a command.
//   A front stage decodes commands into a two-entry queue; a back stage runs them
//   against a circular store of CAPACITY entries (one write and one registered
//   read port) and owns the output register, so input keeps flowing while a
//   result waits.
//   Inserts and rejected commands (full, empty, invalid position) pass the queue
//   entry and then the output register; these retire one per cycle while out_o.ready.
//   Delete at position p of n elements: each of the n-1-p elements behind p
//   moves down one slot to close the gap, taking one store read and one store write.
//   Dump of n elements: the first word passes the queue entry, S_DUMP_RD, the store
//   read register and the output register, then one word per cycle while out_o.ready.
//   Commands are handled one at a time by the back stage.
//   Reset empties the list (head and count cleared); store contents are not
//   cleared and no clearing pass is needed.
//   When the receiver stalls, the output word holds, the back stage waits, and
//   in_i.ready drops once the queue holds two commands.
module sequence_list_engine import sle_pkg::*; #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sle_in_if.sink    in_i,
  sle_out_if.source out_o
);

  queue_head_t q_head;
  logic        q_pop;

  // front: accept and decode
  sle_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .head_o (q_head),
    .pop_i  (q_pop)
  );

  // back: list operations and result words
  sle_back #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (q_head),
    .pop_o  (q_pop),
    .out_o  (out_o)
  );

endmodule
